>>> src/aarm_pkg.sv
// Package for the axis-angle to rotation matrix block: shared constants,
// the CORDIC arctangent table and the structs passed between pipeline cells.
// No dependencies.
package aarm_pkg;

   localparam int SQRT_STEPS   = 32;
   localparam int CORDIC_STEPS = 30;
   localparam int DIV_BITS     = 31;

   localparam logic signed [34:0] HALF_PI_Q30     = 35'sd1686629713;
   localparam logic signed [34:0] PI_Q30          = 35'sd3373259426;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [33:0] ONE_Q30         = 34'sd1073741824;

   localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
      30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
      30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
      30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
      30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
      30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
      30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002
   };

   typedef struct packed {
      logic [2:0]  sgn;
      logic        zero;
      logic        fold;
      logic [34:0] z;
   } tag_type;

   typedef struct packed {
      logic [63:0]      rem;
      logic [63:0]      root;
      logic [2:0][29:0] nm;
      tag_type          tag;
      logic [33:0]      x;
      logic [33:0]      y;
   } cell_type;

   typedef struct packed {
      logic [30:0]      len;
      logic [2:0][30:0] rem;
      logic [2:0][30:0] q;
      logic [2:0]       sgn;
      logic             zero;
      logic             fold;
      logic [33:0]      x;
      logic [33:0]      y;
   } div_type;

   typedef struct packed {
      logic [8:0][31:0] m;
      logic             zero;
   } res_type;

endpackage

>>> src/aarm_front.sv
// Front pipeline: magnitudes, block normalization shift, sum of squares and
// angle fold. Depends on aarm_pkg; feeds the first aarm_cell.
module aarm_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [31:0]        axis_x,
   input  logic [31:0]        axis_y,
   input  logic [31:0]        axis_z,
   input  logic [30:0]        angle,
   output logic               out_valid,
   output aarm_pkg::cell_type out_data
);

   logic [5:0]        v_ff;
   aarm_pkg::tag_type t1_ff, t2_ff, t3_ff, t4_ff, t5_ff;
   aarm_pkg::tag_type t1_in;
   logic [2:0][31:0]  mag1_ff, mag2_ff, mag3_ff, mag1_in;
   logic [31:0]       mx2_ff, mx2_in;
   logic [4:0]        p3_ff, p3_in;
   logic [2:0][29:0]  nm4_ff, nm5_ff, nm4_in;
   logic [2:0][59:0]  sq5_ff;
   aarm_pkg::cell_type out_in;
   logic [2:0][31:0]  ax;
   logic signed [34:0] a;

   always_comb begin
      ax = {axis_z, axis_y, axis_x};
      for (int i = 0; i < 3; i++) begin
         mag1_in[i]   = ax[i][31] ? (32'd0 - ax[i]) : ax[i];
         t1_in.sgn[i] = ax[i][31];
      end
      t1_in.zero = (axis_x == 32'd0) && (axis_y == 32'd0) && (axis_z == 32'd0);
      a = {{2{angle[30]}}, angle, 2'b00};
      t1_in.fold = 1'b0;
      t1_in.z    = a;
      if (a > aarm_pkg::HALF_PI_Q30) begin
         t1_in.z    = a - aarm_pkg::PI_Q30;
         t1_in.fold = 1'b1;
      end else if (a < -aarm_pkg::HALF_PI_Q30) begin
         t1_in.z    = a + aarm_pkg::PI_Q30;
         t1_in.fold = 1'b1;
      end
   end

   always_comb begin
      mx2_in = mag1_ff[0];
      if (mag1_ff[1] > mx2_in) mx2_in = mag1_ff[1];
      if (mag1_ff[2] > mx2_in) mx2_in = mag1_ff[2];
   end

   always_comb begin
      p3_in = 5'd0;
      for (int b = 0; b < 32; b++) begin
         if (mx2_ff[b]) p3_in = 5'(b);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (p3_ff >= 5'd30) nm4_in[i] = 30'(mag3_ff[i] >> (p3_ff - 5'd29));
         else nm4_in[i] = 30'(mag3_ff[i] << (5'd29 - p3_ff));
      end
   end

   always_comb begin
      out_in.rem  = 64'(sq5_ff[0]) + 64'(sq5_ff[1]) + 64'(sq5_ff[2]);
      out_in.root = 64'd0;
      out_in.nm   = nm5_ff;
      out_in.tag  = t5_ff;
      out_in.x    = aarm_pkg::CORDIC_GAIN_Q30;
      out_in.y    = 34'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 6'd0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff   <= t1_in;
         mag1_ff <= mag1_in;
         t2_ff   <= t1_ff;
         mag2_ff <= mag1_ff;
         mx2_ff  <= mx2_in;
         t3_ff   <= t2_ff;
         mag3_ff <= mag2_ff;
         p3_ff   <= p3_in;
         t4_ff   <= t3_ff;
         nm4_ff  <= nm4_in;
         t5_ff   <= t4_ff;
         nm5_ff  <= nm4_ff;
         for (int i = 0; i < 3; i++) sq5_ff[i] <= 60'(nm4_ff[i]) * 60'(nm4_ff[i]);
         out_data <= out_in;
      end
   end

   assign out_valid = v_ff[5];

endmodule

>>> src/aarm_cell.sv
// One cell of the main chain: one square root iteration and, in the first
// cells, one CORDIC rotation. Depends on aarm_pkg.
module aarm_cell #(
   parameter int STEP = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  aarm_pkg::cell_type in_data,
   output logic               out_valid,
   output aarm_pkg::cell_type out_data
);

   localparam logic [63:0] SqBit = 64'd1 << (62 - 2 * STEP);

   logic               valid_ff;
   aarm_pkg::cell_type data_in;
   logic [63:0]        t;
   logic signed [33:0] x_n, y_n;
   logic signed [34:0] z_n;

   if (STEP < aarm_pkg::CORDIC_STEPS) begin : g_rot
      logic signed [33:0] xs, ys, dx, dy;
      logic signed [34:0] zs, at;
      always_comb begin
         xs = in_data.x;
         ys = in_data.y;
         zs = in_data.tag.z;
         dx = ys >>> STEP;
         dy = xs >>> STEP;
         at = {5'd0, aarm_pkg::ATAN_Q30[STEP]};
         if (!in_data.tag.z[34]) begin
            x_n = xs - dx;
            y_n = ys + dy;
            z_n = zs - at;
         end else begin
            x_n = xs + dx;
            y_n = ys - dy;
            z_n = zs + at;
         end
      end
   end else begin : g_hold
      assign x_n = in_data.x;
      assign y_n = in_data.y;
      assign z_n = in_data.tag.z;
   end

   always_comb begin
      data_in = in_data;
      t = in_data.root + SqBit;
      if (in_data.rem >= t) begin
         data_in.rem  = in_data.rem - t;
         data_in.root = (in_data.root >> 1) + SqBit;
      end else begin
         data_in.root = in_data.root >> 1;
      end
      data_in.x     = x_n;
      data_in.y     = y_n;
      data_in.tag.z = z_n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) out_data <= data_in;
   end

   assign out_valid = valid_ff;

endmodule

>>> src/aarm_div_cell.sv
// One cell of the divider chain: one quotient bit of each unit component.
// Depends on aarm_pkg.
module aarm_div_cell #(
   parameter int BIT = 30
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  aarm_pkg::div_type in_data,
   output logic              out_valid,
   output aarm_pkg::div_type out_data
);

   logic              valid_ff;
   aarm_pkg::div_type data_in;
   logic [32:0]       t, r;
   logic              ge;

   always_comb begin
      data_in = in_data;
      t  = 33'd0;
      r  = 33'd0;
      ge = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (BIT == aarm_pkg::DIV_BITS - 1) t = {2'b00, in_data.rem[i]};
         else t = {1'b0, in_data.rem[i], 1'b0};
         ge = t >= {2'b00, in_data.len};
         r  = ge ? (t - {2'b00, in_data.len}) : t;
         data_in.rem[i]    = r[30:0];
         data_in.q[i][BIT] = ge;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) out_data <= data_in;
   end

   assign out_valid = valid_ff;

endmodule

>>> src/aarm_back.sv
// Back pipeline: unit axis, clamped sine and cosine, Rodrigues products,
// entry saturation and the output register. Depends on aarm_pkg.
module aarm_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  aarm_pkg::div_type in_data,
   output logic              out_valid,
   output aarm_pkg::res_type out_data
);

   localparam int PA [6] = '{0, 1, 2, 0, 0, 1};
   localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

   function automatic logic [31:0] sat(input logic signed [33:0] v);
      logic signed [33:0] r;
      r = v;
      if (v > aarm_pkg::ONE_Q30) r = aarm_pkg::ONE_Q30;
      if (v < -aarm_pkg::ONE_Q30) r = -aarm_pkg::ONE_Q30;
      return r[31:0];
   endfunction

   logic [3:0] v_ff;

   logic signed [2:0][31:0] u1_ff, u1_in;
   logic signed [31:0]      c1_ff, s1_ff, c1_in, s1_in;
   logic                    z1_ff, z2_ff, z3_ff;
   logic signed [33:0]      xf, yf;

   logic signed [5:0][31:0] pp2_ff, pp2_in;
   logic signed [2:0][31:0] us2_ff, us2_in, us3_ff;
   logic signed [32:0]      omc2_ff;
   logic signed [31:0]      c2_ff, c3_ff;
   logic signed [63:0]      prod;

   logic signed [5:0][32:0] d3_ff, d3_in;
   logic signed [64:0]      prod3;

   aarm_pkg::res_type       res_in;
   logic signed [33:0]      cw;
   logic signed [5:0][33:0] dw;
   logic signed [2:0][33:0] uw;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u1_in[i] = in_data.sgn[i] ? (32'd0 - {1'b0, in_data.q[i]}) : {1'b0, in_data.q[i]};
      end
      xf = in_data.fold ? (34'sd0 - $signed(in_data.x)) : $signed(in_data.x);
      yf = in_data.fold ? (34'sd0 - $signed(in_data.y)) : $signed(in_data.y);
      c1_in = sat(xf);
      s1_in = sat(yf);
   end

   always_comb begin
      prod = 64'sd0;
      for (int k = 0; k < 6; k++) begin
         prod      = 64'($signed(u1_ff[PA[k]])) * 64'($signed(u1_ff[PB[k]]));
         pp2_in[k] = 32'(prod >>> 30);
      end
      for (int i = 0; i < 3; i++) begin
         prod      = 64'($signed(u1_ff[i])) * 64'(s1_ff);
         us2_in[i] = 32'(prod >>> 30);
      end
   end

   always_comb begin
      prod3 = 65'sd0;
      for (int k = 0; k < 6; k++) begin
         prod3    = 65'($signed(pp2_ff[k])) * 65'(omc2_ff);
         d3_in[k] = 33'(prod3 >>> 30);
      end
   end

   always_comb begin
      cw = 34'(c3_ff);
      for (int k = 0; k < 6; k++) dw[k] = 34'($signed(d3_ff[k]));
      for (int i = 0; i < 3; i++) uw[i] = 34'($signed(us3_ff[i]));
      res_in.m[0] = sat(cw + dw[0]);
      res_in.m[1] = sat(dw[3] - uw[2]);
      res_in.m[2] = sat(dw[4] + uw[1]);
      res_in.m[3] = sat(dw[3] + uw[2]);
      res_in.m[4] = sat(cw + dw[1]);
      res_in.m[5] = sat(dw[5] - uw[0]);
      res_in.m[6] = sat(dw[4] - uw[1]);
      res_in.m[7] = sat(dw[5] + uw[0]);
      res_in.m[8] = sat(cw + dw[2]);
      res_in.zero = z3_ff;
      if (z3_ff) begin
         res_in.m = '0;
         res_in.m[0] = 32'h4000_0000;
         res_in.m[4] = 32'h4000_0000;
         res_in.m[8] = 32'h4000_0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 4'd0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u1_ff    <= u1_in;
         c1_ff    <= c1_in;
         s1_ff    <= s1_in;
         z1_ff    <= in_data.zero;
         pp2_ff   <= pp2_in;
         us2_ff   <= us2_in;
         omc2_ff  <= 33'sh4000_0000 - 33'(c1_ff);
         c2_ff    <= c1_ff;
         z2_ff    <= z1_ff;
         d3_ff    <= d3_in;
         us3_ff   <= us2_ff;
         c3_ff    <= c2_ff;
         z3_ff    <= z2_ff;
         out_data <= res_in;
      end
   end

   assign out_valid = v_ff[3];

endmodule

>>> src/axis_angle_to_rotation_matrix_top.sv
// Axis-angle to rotation matrix by Rodrigues' formula. An accepted item passes
// through 6 front stages, 32 square root and CORDIC cells, 31 divider cells
// and 4 back stages with the output register.
// Throughput is one item per cycle; a stalled result freezes the whole chain.
// Synchronous reset clears all valid flags; payload registers are not reset.
module axis_angle_to_rotation_matrix_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_axis_x,
   input  logic [31:0] req_axis_y,
   input  logic [31:0] req_axis_z,
   input  logic [30:0] req_angle,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_m11,
   output logic [31:0] rsp_m12,
   output logic [31:0] rsp_m13,
   output logic [31:0] rsp_m21,
   output logic [31:0] rsp_m22,
   output logic [31:0] rsp_m23,
   output logic [31:0] rsp_m31,
   output logic [31:0] rsp_m32,
   output logic [31:0] rsp_m33,
   output logic        rsp_zero_axis
);

   logic en;
   logic [aarm_pkg::SQRT_STEPS:0] cv;
   aarm_pkg::cell_type            cd [aarm_pkg::SQRT_STEPS+1];
   logic [aarm_pkg::DIV_BITS:0]   dv;
   aarm_pkg::div_type             dd [aarm_pkg::DIV_BITS+1];
   aarm_pkg::res_type             res;

   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   aarm_front u_front (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid),
      .axis_x(req_axis_x), .axis_y(req_axis_y), .axis_z(req_axis_z),
      .angle(req_angle), .out_valid(cv[0]), .out_data(cd[0])
   );

   for (genvar k = 0; k < aarm_pkg::SQRT_STEPS; k++) begin : g_cell
      aarm_cell #(.STEP(k)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(cv[k]), .in_data(cd[k]),
         .out_valid(cv[k+1]), .out_data(cd[k+1])
      );
   end

   always_comb begin
      dd[0].len  = cd[aarm_pkg::SQRT_STEPS].root[30:0];
      for (int i = 0; i < 3; i++) begin
         dd[0].rem[i] = {1'b0, cd[aarm_pkg::SQRT_STEPS].nm[i]};
      end
      dd[0].q    = '0;
      dd[0].sgn  = cd[aarm_pkg::SQRT_STEPS].tag.sgn;
      dd[0].zero = cd[aarm_pkg::SQRT_STEPS].tag.zero;
      dd[0].fold = cd[aarm_pkg::SQRT_STEPS].tag.fold;
      dd[0].x    = cd[aarm_pkg::SQRT_STEPS].x;
      dd[0].y    = cd[aarm_pkg::SQRT_STEPS].y;
   end
   assign dv[0] = cv[aarm_pkg::SQRT_STEPS];

   for (genvar k = 0; k < aarm_pkg::DIV_BITS; k++) begin : g_div
      aarm_div_cell #(.BIT(aarm_pkg::DIV_BITS - 1 - k)) u_div (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(dv[k]), .in_data(dd[k]),
         .out_valid(dv[k+1]), .out_data(dd[k+1])
      );
   end

   aarm_back u_back (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(dv[aarm_pkg::DIV_BITS]), .in_data(dd[aarm_pkg::DIV_BITS]),
      .out_valid(rsp_valid), .out_data(res)
   );

   assign rsp_m11       = res.m[0];
   assign rsp_m12       = res.m[1];
   assign rsp_m13       = res.m[2];
   assign rsp_m21       = res.m[3];
   assign rsp_m22       = res.m[4];
   assign rsp_m23       = res.m[5];
   assign rsp_m31       = res.m[6];
   assign rsp_m32       = res.m[7];
   assign rsp_m33       = res.m[8];
   assign rsp_zero_axis = res.zero;

endmodule

>>> src/aarm_checker.sv
// Port-level checks for the axis-angle to rotation matrix block, and the bind
// that attaches them to the top level. Depends on the top level's ports.
module aarm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_m11,
   input logic [31:0] rsp_m12,
   input logic [31:0] rsp_m13,
   input logic [31:0] rsp_m21,
   input logic [31:0] rsp_m22,
   input logic [31:0] rsp_m23,
   input logic [31:0] rsp_m31,
   input logic [31:0] rsp_m32,
   input logic [31:0] rsp_m33,
   input logic        rsp_zero_axis
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_m11) && $stable(rsp_m23)
         && $stable(rsp_zero_axis))
      else $error("stalled result changed");

   a_stall_path: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output stall");

   a_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_axis |-> rsp_m11 == 32'h4000_0000
         && rsp_m22 == 32'h4000_0000 && rsp_m33 == 32'h4000_0000
         && rsp_m12 == 32'd0 && rsp_m13 == 32'd0 && rsp_m21 == 32'd0
         && rsp_m23 == 32'd0 && rsp_m31 == 32'd0 && rsp_m32 == 32'd0)
      else $error("zero axis result is not the identity");

   a_diag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed(rsp_m11) <= 32'sh4000_0000
         && $signed(rsp_m11) >= -32'sh4000_0000
         && $signed(rsp_m33) <= 32'sh4000_0000
         && $signed(rsp_m33) >= -32'sh4000_0000)
      else $error("diagonal entry out of range");

endmodule

bind axis_angle_to_rotation_matrix_top aarm_checker u_aarm_checker (.*);
